### sv/scrh_pkg.sv
// Shared types, constants and codes for the substring compare block.
package scrh_pkg;
	localparam int MaxLen = 4096;
	localparam int IdxW = $clog2(MaxLen);
	localparam int LenW = $clog2(MaxLen + 1);
	localparam int HashW = 30;
	localparam logic [HashW-1:0] HashMod = 30'd1000000009;
	localparam logic [5:0] HashBase = 6'd37;

	localparam logic [1:0] CMD_APPEND = 2'd0;
	localparam logic [1:0] CMD_QUERY = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	typedef struct packed {
		logic [1:0] command;
		logic [7:0] symbol;
		logic [11:0] first_start;
		logic [11:0] first_end;
		logic [11:0] second_start;
		logic [11:0] second_end;
	} in_item_t;

	typedef struct packed {
		logic signed [1:0] order;
		logic bad_request;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_APP_MUL, ST_APP_WR, ST_Q_SETUP, ST_P_RD, ST_P_MUL1, ST_P_MUL2,
		ST_P_MUL3, ST_P_CMP, ST_C_RD, ST_C_CMP, ST_OUT
	} state_t;

	typedef struct packed {
		logic start;
		logic [HashW-1:0] a;
		logic [HashW-1:0] b;
	} mul_req_t;

	// (x mod 26) + 2 for a byte
	function automatic logic [4:0] sym_code(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (r >= 8'd208) r = r - 8'd208;
		if (r >= 8'd104) r = r - 8'd104;
		if (r >= 8'd52) r = r - 8'd52;
		if (r >= 8'd26) r = r - 8'd26;
		return r[4:0] + 5'd2;
	endfunction
endpackage

### sv/scrh_modmul.sv
// Shift-add modular multiplier: one bit of the multiplier per cycle.
module scrh_modmul (
	input logic clk,
	input logic arst_n,
	input scrh_pkg::mul_req_t req,
	output logic busy,
	output logic [scrh_pkg::HashW-1:0] prod
);
	import scrh_pkg::*;
	localparam int CntW = $clog2(HashW + 1);
	logic [HashW-1:0] acc_q, a_q, b_q;
	logic [CntW-1:0] cnt_q;
	logic [HashW:0] dbl, dbl_r, sum;
	logic [HashW-1:0] acc_d;

	always_comb begin
		dbl = {acc_q, 1'b0};
		dbl_r = (dbl >= {1'b0, HashMod}) ? dbl - {1'b0, HashMod} : dbl;
		sum = dbl_r + (b_q[HashW-1] ? {1'b0, a_q} : '0);
		acc_d = (sum >= {1'b0, HashMod}) ? HashW'(sum - {1'b0, HashMod}) : sum[HashW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (req.start) begin
			cnt_q <= CntW'(HashW);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= '0;
			a_q <= req.a;
			b_q <= req.b;
		end else if (cnt_q != '0) begin
			acc_q <= acc_d;
			b_q <= {b_q[HashW-2:0], 1'b0};
		end
	end

	assign busy = (cnt_q != '0);
	assign prod = acc_q;
endmodule

### sv/substring_compare_rolling_hash_top.sv
// Top level: string store, hash tables, sequencer and output register.
// Append runs two sequential modular multiplies (hash, then power) on one shared
// shift-add multiplier. Clear and rejected requests go straight to the output
// state. A query is a binary search; each probe is a setup step, four table
// reads, two sequential multiplies and a compare. A full-length range needs up
// to 13 probes, plus setup and the final byte compare. One item is processed
// at a time; in is ready only while the sequencer is idle. The result sits in
// its own output register, so the next transfer can be taken while a result
// waits.
// Tables are single-port memories with registered reads. Entry zero of the hash
// and power tables is a constant, so there is no clearing pass.
module substring_compare_rolling_hash_top (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input scrh_pkg::in_item_t in_data,
	output logic out_valid,
	input logic out_stall,
	output scrh_pkg::out_item_t out_data
);
	import scrh_pkg::*;

	logic [7:0] chars [MaxLen];
	logic [HashW-1:0] ph [MaxLen+1];
	logic [HashW-1:0] pw [MaxLen+1];

	state_t st_q, st_d;
	in_item_t it_q;
	logic [LenW-1:0] len_q;
	logic [LenW-1:0] lo_q, hi_q, mn_q, mid_q;
	logic [LenW-1:0] len1, len2;
	logic [HashW-1:0] h1hi_q, h1lo_q, h2hi_q, h2lo_q, pwm_q, t_q;
	logic [7:0] c1_q;
	logic [1:0] ph_step_q;
	logic [HashW-1:0] ph_rd_q, pw_rd_q;
	logic [7:0] ch_rd_q;
	logic [LenW-1:0] ph_addr, pw_addr;
	logic [IdxW-1:0] ch_addr;
	logic ph_we, pw_we, ch_we;
	logic [HashW-1:0] ph_wd, pw_wd;
	mul_req_t mreq;
	logic mbusy;
	logic [HashW-1:0] mprod;
	out_item_t res_q;
	out_item_t out_q;
	logic ov_q;
	logic [HashW:0] hs1, hs2;
	logic [HashW-1:0] r1, r2;
	logic q_bad, app_full;

	scrh_modmul u_mul (.clk, .arst_n, .req(mreq), .busy(mbusy), .prod(mprod));

	assign len1 = LenW'(it_q.first_end) - LenW'(it_q.first_start) + 1'b1;
	assign len2 = LenW'(it_q.second_end) - LenW'(it_q.second_start) + 1'b1;

	assign q_bad = in_data.first_end < in_data.first_start
		|| in_data.second_end < in_data.second_start
		|| LenW'(in_data.first_end) >= len_q
		|| LenW'(in_data.second_end) >= len_q;
	assign app_full = (len_q == LenW'(MaxLen));

	// range hash: hi - lo*pw mod p
	always_comb begin
		hs1 = {1'b0, h1hi_q} + {1'b0, HashMod} - {1'b0, h1lo_q};
		hs2 = {1'b0, h2hi_q} + {1'b0, HashMod} - {1'b0, h2lo_q};
		r1 = (hs1 >= {1'b0, HashMod}) ? HashW'(hs1 - {1'b0, HashMod}) : hs1[HashW-1:0];
		r2 = (hs2 >= {1'b0, HashMod}) ? HashW'(hs2 - {1'b0, HashMod}) : hs2[HashW-1:0];
	end

	// memories
	always_ff @(posedge clk) begin
		if (ph_we) ph[ph_addr] <= ph_wd;
		ph_rd_q <= ph[ph_addr];
		if (pw_we) pw[pw_addr] <= pw_wd;
		pw_rd_q <= pw[pw_addr];
		if (ch_we) chars[ch_addr] <= it_q.symbol;
		ch_rd_q <= chars[ch_addr];
	end

	always_comb begin
		st_d = st_q;
		mreq = '0;
		ph_we = 1'b0;
		pw_we = 1'b0;
		ch_we = 1'b0;
		ph_wd = '0;
		pw_wd = '0;
		ph_addr = len_q;
		pw_addr = len_q;
		ch_addr = len_q[IdxW-1:0];
		case (st_q)
			ST_IDLE: begin
				if (in_valid) begin
					case (in_data.command)
						CMD_APPEND: st_d = app_full ? ST_OUT : ST_APP_MUL;
						CMD_CLEAR: st_d = ST_OUT;
						CMD_QUERY: st_d = q_bad ? ST_OUT : ST_Q_SETUP;
						default: st_d = ST_IDLE;
					endcase
				end
			end
			ST_APP_MUL: begin
				if (!mbusy) begin
					mreq.start = 1'b1;
					mreq.a = (len_q == '0) ? '0 : ph_rd_q;
					mreq.b = HashW'(HashBase);
					st_d = ST_APP_WR;
				end
			end
			ST_APP_WR: begin
				// first mul result: hash; then power
				if (!mbusy) begin
					if (ph_step_q == 2'd0) begin
						mreq.start = 1'b1;
						mreq.a = (len_q == '0) ? HashW'(1) : pw_rd_q;
						mreq.b = HashW'(HashBase);
					end else begin
						ph_we = 1'b1;
						pw_we = 1'b1;
						ch_we = 1'b1;
						ph_addr = len_q + 1'b1;
						pw_addr = len_q + 1'b1;
						ph_wd = t_q;
						pw_wd = mprod;
						st_d = ST_OUT;
					end
				end
			end
			ST_Q_SETUP: begin
				if (mn_q == '0) st_d = ST_Q_SETUP;
				else st_d = (lo_q + 1'b1 < hi_q) ? ST_P_RD : ST_C_RD;
			end
			ST_P_RD: begin
				// ph_step: 0 ph[s1+m],1 ph[s1],2 ph[s2+m],3 ph[s2]; pw[m] alongside
				pw_addr = mid_q;
				case (ph_step_q)
					2'd0: ph_addr = LenW'(it_q.first_start) + mid_q;
					2'd1: ph_addr = LenW'(it_q.first_start);
					2'd2: ph_addr = LenW'(it_q.second_start) + mid_q;
					default: ph_addr = LenW'(it_q.second_start);
				endcase
				st_d = ST_P_MUL1;
			end
			ST_P_MUL1: begin
				pw_addr = mid_q;
				if (ph_step_q == 2'd3) st_d = ST_P_MUL2;
				else st_d = ST_P_RD;
			end
			ST_P_MUL2: begin
				mreq.start = 1'b1;
				mreq.a = h1lo_q;
				mreq.b = pwm_q;
				st_d = ST_P_MUL3;
			end
			ST_P_MUL3: begin
				if (!mbusy) begin
					if (ph_step_q == 2'd0) begin
						mreq.start = 1'b1;
						mreq.a = h2lo_q;
						mreq.b = pwm_q;
					end else begin
						st_d = ST_P_CMP;
					end
				end
			end
			ST_P_CMP: st_d = ST_Q_SETUP;
			ST_C_RD: begin
				ch_addr = (ph_step_q == 2'd0) ? IdxW'(LenW'(it_q.first_start) + lo_q)
					: IdxW'(LenW'(it_q.second_start) + lo_q);
				st_d = ST_C_CMP;
			end
			ST_C_CMP: begin
				if (ph_step_q == 2'd0) st_d = ST_C_RD;
				else st_d = ST_OUT;
			end
			ST_OUT: if (!ov_q) st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	assign in_stall = (st_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			len_q <= '0;
			ov_q <= 1'b0;
			ph_step_q <= '0;
		end else begin
			st_q <= st_d;
			if (ov_q && !out_stall) ov_q <= 1'b0;
			case (st_q)
				ST_IDLE: begin
					ph_step_q <= '0;
					if (in_valid && in_data.command == CMD_CLEAR) len_q <= '0;
				end
				ST_APP_WR: begin
					if (!mbusy) begin
						if (ph_step_q == 2'd0) ph_step_q <= 2'd1;
						else len_q <= len_q + 1'b1;
					end
				end
				ST_P_MUL1: ph_step_q <= ph_step_q + 1'b1;
				ST_P_MUL3: if (!mbusy && ph_step_q == 2'd0) ph_step_q <= 2'd1;
				ST_P_CMP: ph_step_q <= '0;
				ST_C_CMP: ph_step_q <= ph_step_q + 1'b1;
				ST_OUT: if (!ov_q) ov_q <= 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				it_q <= in_data;
				res_q <= '{order: 2'sd0,
					bad_request: (in_data.command == CMD_APPEND && app_full)
						|| (in_data.command == CMD_QUERY && q_bad)};
				lo_q <= '0;
			end
			ST_APP_WR: if (!mbusy && ph_step_q == 2'd0)
				t_q <= (mprod + HashW'(sym_code(it_q.symbol)) >= HashMod)
					? mprod + HashW'(sym_code(it_q.symbol)) - HashMod
					: mprod + HashW'(sym_code(it_q.symbol));
			ST_Q_SETUP: begin
				mid_q <= LenW'(({1'b0, lo_q} + {1'b0, hi_q}) >> 1);
			end
			ST_P_MUL1: begin
				pwm_q <= pw_rd_q;
				// entry zero of the hash table is never written; it is 0
				case (ph_step_q)
					2'd0: h1hi_q <= ph_rd_q;
					2'd1: h1lo_q <= (it_q.first_start == '0) ? '0 : ph_rd_q;
					2'd2: h2hi_q <= ph_rd_q;
					default: h2lo_q <= (it_q.second_start == '0) ? '0 : ph_rd_q;
				endcase
			end
			ST_P_MUL3: if (!mbusy) begin
				if (ph_step_q == 2'd0) h1lo_q <= mprod;
				else h2lo_q <= mprod;
			end
			ST_P_CMP: begin
				if (r1 == r2) lo_q <= mid_q;
				else hi_q <= mid_q;
			end
			ST_C_CMP: begin
				if (ph_step_q == 2'd0) begin
					c1_q <= ch_rd_q;
				end else if (lo_q >= mn_q) begin
					if (len1 == len2) res_q.order <= 2'sd0;
					else res_q.order <= (len1 < len2) ? -2'sd1 : 2'sd1;
				end else begin
					res_q.order <= (c1_q < ch_rd_q) ? -2'sd1 : 2'sd1;
				end
			end
			ST_OUT: if (!ov_q) out_q <= res_q;
			default: ;
		endcase
		if (st_q == ST_IDLE) begin
			mn_q <= '0;
			hi_q <= '0;
		end else if (st_q == ST_Q_SETUP && mn_q == '0) begin
			mn_q <= (len1 < len2) ? len1 : len2;
			hi_q <= ((len1 < len2) ? len1 : len2) + 1'b1;
		end
	end

	// setup state loops once on entry to latch mn and hi before probing
	assign out_valid = ov_q;
	assign out_data = out_q;
endmodule

### sv/scrh_checker.sv
// Port-level checker for the substring compare block, bound to the top.
module scrh_checker (
	input logic clk,
	input logic arst_n,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input scrh_pkg::out_item_t out_data
);
	import scrh_pkg::*;
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.bad_request |-> out_data.order == 2'sd0)
		else $error("flagged result with nonzero order");
	a_order_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.order != 2'b10)
		else $error("illegal order code");
	a_out_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result raised without the sequencer busy");
endmodule

bind substring_compare_rolling_hash_top scrh_checker u_chk (.clk, .arst_n,
	.in_stall, .out_valid, .out_stall, .out_data);
